// File: hw/rtl/tbpf_pkg.sv
// Shared types, widths, status codes and the tangent table for the two-bearing position fix.
// Depends on nothing; all other files refer to it by scoped names.
package tbpf_pkg;

  // Field widths
  localparam int BEAR_W        = 9;
  localparam int COORD_W       = 32;
  localparam int ST_W          = 2;
  localparam int TAN_FRAC_BITS = 16;

  // Angle arithmetic
  localparam int ANG_MOD     = 180;
  localparam int ANG_HALF    = 90;
  localparam int ANG_W       = 8;
  localparam int SUM_W       = BEAR_W + 1;
  localparam int RED_STEPS   = ((2 ** SUM_W) - 1) / ANG_MOD;
  localparam int TAB_IDX_W   = 7;

  // Tangent below 90 degrees stays under 2^(TAN_FRAC_BITS+6)
  localparam int TAN_W   = TAN_FRAC_BITS + 8;

  // Datapath widths
  localparam int PROD_W  = TAN_W + COORD_W;
  localparam int YD_W    = COORD_W + 1;
  localparam int NUM_W   = PROD_W + 2;
  localparam int DEN_W   = TAN_W + 1;
  localparam int NMAG_W  = NUM_W - 1;
  localparam int DMAG_W  = TAN_W;
  localparam int YP_W    = TAN_W + YD_W;
  localparam int YQ_W    = YP_W - TAN_FRAC_BITS;
  localparam int YS_W    = YQ_W + 1;

  typedef enum logic [ST_W-1:0] {
    ST_OK       = 2'd0,
    ST_PARALLEL = 2'd1,
    ST_VERTICAL = 2'd2,
    ST_SAT      = 2'd3
  } status_t;

  // Data that rides alongside the divider
  typedef struct packed {
    logic signed [TAN_W-1:0]   ta;
    logic signed [COORD_W-1:0] xa;
    logic signed [COORD_W-1:0] ya;
    status_t                   st;
  } side_t;

  typedef logic [TAN_W-2:0] tan_mag_t;
  typedef tan_mag_t tan_rom_t [ANG_HALF];

  // Unsigned 64-bit quotient by shift and subtract, used only to build the table
  function automatic longint unsigned udiv64(longint unsigned a, longint unsigned b);
    logic [64:0]     rem;
    longint unsigned q;
    rem = '0;
    q   = '0;
    for (int i = 63; i >= 0; i--) begin
      rem = {rem[63:0], a[i]};
      if (rem >= {1'b0, b}) begin
        rem  = rem - {1'b0, b};
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  // Tangent of 0..89 degrees from Taylor sums in Q2.30, rounded to TAN_FRAC_BITS
  function automatic tan_rom_t build_tan_rom();
    tan_rom_t        rom;
    longint unsigned r;
    longint unsigned r2;
    longint unsigned ts;
    longint unsigned tc;
    longint unsigned t24;
    longint unsigned n;
    longint          s;
    longint          c;
    int              sh;
    sh = 24 - TAN_FRAC_BITS;
    for (int k = 0; k < ANG_HALF; k++) begin
      r  = udiv64(longint'(k) * 64'd3373259422 + 64'd90, 64'd180);
      r2 = (r * r) >> 30;
      ts = r;
      tc = 64'd1073741824;
      s  = longint'(r);
      c  = 64'sd1073741824;
      for (int i = 1; i <= 12; i++) begin
        n  = longint'(i);
        ts = udiv64((ts * r2) >> 30, (2 * n) * (2 * n + 1));
        tc = udiv64((tc * r2) >> 30, (2 * n - 1) * (2 * n));
        if (i[0]) begin
          s = s - longint'(ts);
          c = c - longint'(tc);
        end else begin
          s = s + longint'(ts);
          c = c + longint'(tc);
        end
      end
      if (s < 0) s = 0;
      if (c <= 0) c = 1;
      t24 = udiv64(($unsigned(s) << 24) + ($unsigned(c) >> 1), $unsigned(c));
      if (sh > 0) begin
        t24 = (t24 + (64'd1 << (sh - 1))) >> sh;
      end
      rom[k] = t24[TAN_W-2:0];
    end
    return rom;
  endfunction

  localparam tan_rom_t TAN_ROM = build_tan_rom();

endpackage

// File: hw/rtl/tbpf_front.sv
// Front stages: bearing reduction, tangent lookup, products and numerator/denominator.
// Depends on tbpf_pkg.
module tbpf_front (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               en,
  input  logic [tbpf_pkg::BEAR_W-1:0]        north_offset,
  input  logic                               in_vld,
  input  logic [tbpf_pkg::BEAR_W-1:0]        bearing_a,
  input  logic [tbpf_pkg::BEAR_W-1:0]        bearing_b,
  input  logic signed [tbpf_pkg::COORD_W-1:0] ref_a_x,
  input  logic signed [tbpf_pkg::COORD_W-1:0] ref_a_y,
  input  logic signed [tbpf_pkg::COORD_W-1:0] ref_b_x,
  input  logic signed [tbpf_pkg::COORD_W-1:0] ref_b_y,
  output logic                               out_vld,
  output logic signed [tbpf_pkg::NUM_W-1:0]  num,
  output logic signed [tbpf_pkg::DEN_W-1:0]  den,
  output tbpf_pkg::side_t                    side
);

  // Stage 1 registers
  logic                                vld1;
  logic [tbpf_pkg::ANG_W-1:0]          aa1, ab1;
  logic signed [tbpf_pkg::COORD_W-1:0] xa1, ya1, xb1, yb1;
  // Stage 2 registers
  logic                                vld2;
  logic signed [tbpf_pkg::TAN_W-1:0]   ta2, tb2;
  logic                                vert2;
  logic signed [tbpf_pkg::COORD_W-1:0] xa2, ya2, xb2, yb2;
  // Stage 3 registers
  logic                                vld3;
  logic signed [tbpf_pkg::PROD_W-1:0]  pa3, pb3;
  logic signed [tbpf_pkg::YD_W-1:0]    yd3;
  logic signed [tbpf_pkg::TAN_W-1:0]   ta3, tb3;
  tbpf_pkg::status_t                   st3;
  logic signed [tbpf_pkg::COORD_W-1:0] xa3, ya3;

  logic [tbpf_pkg::SUM_W-1:0]          sa, sb;
  logic signed [tbpf_pkg::TAN_W-1:0]   ta_next, tb_next;

  // Reduce bearing plus offset modulo 180
  always_comb begin
    sa = tbpf_pkg::SUM_W'(bearing_a) + tbpf_pkg::SUM_W'(north_offset);
    sb = tbpf_pkg::SUM_W'(bearing_b) + tbpf_pkg::SUM_W'(north_offset);
    for (int k = 0; k < tbpf_pkg::RED_STEPS; k++) begin
      if (sa >= tbpf_pkg::SUM_W'(tbpf_pkg::ANG_MOD)) sa = sa - tbpf_pkg::SUM_W'(tbpf_pkg::ANG_MOD);
      if (sb >= tbpf_pkg::SUM_W'(tbpf_pkg::ANG_MOD)) sb = sb - tbpf_pkg::SUM_W'(tbpf_pkg::ANG_MOD);
    end
  end

  function automatic logic signed [tbpf_pkg::TAN_W-1:0] line_tan(
    input logic [tbpf_pkg::ANG_W-1:0] a
  );
    logic [tbpf_pkg::ANG_W-1:0] m;
    m = tbpf_pkg::ANG_W'(tbpf_pkg::ANG_MOD) - a;
    if (a < tbpf_pkg::ANG_W'(tbpf_pkg::ANG_HALF)) begin
      return $signed({1'b0, tbpf_pkg::TAN_ROM[a[tbpf_pkg::TAB_IDX_W-1:0]]});
    end else if (a == tbpf_pkg::ANG_W'(tbpf_pkg::ANG_HALF)) begin
      return '0;
    end else begin
      return -$signed({1'b0, tbpf_pkg::TAN_ROM[m[tbpf_pkg::TAB_IDX_W-1:0]]});
    end
  endfunction

  // Look up both tangents
  always_comb begin
    ta_next = line_tan(aa1);
    tb_next = line_tan(ab1);
  end

  // Hold valid bits, clear on reset
  always_ff @(posedge clk) begin
    if (rst) begin
      vld1    <= 1'b0;
      vld2    <= 1'b0;
      vld3    <= 1'b0;
      out_vld <= 1'b0;
    end else if (en) begin
      vld1    <= in_vld;
      vld2    <= vld1;
      vld3    <= vld2;
      out_vld <= vld3;
    end
  end

  // Advance the payload
  always_ff @(posedge clk) begin
    if (en) begin
      aa1   <= sa[tbpf_pkg::ANG_W-1:0];
      ab1   <= sb[tbpf_pkg::ANG_W-1:0];
      xa1   <= ref_a_x;
      ya1   <= ref_a_y;
      xb1   <= ref_b_x;
      yb1   <= ref_b_y;

      ta2   <= ta_next;
      tb2   <= tb_next;
      vert2 <= (aa1 == tbpf_pkg::ANG_W'(tbpf_pkg::ANG_HALF)) ||
               (ab1 == tbpf_pkg::ANG_W'(tbpf_pkg::ANG_HALF));
      xa2   <= xa1;
      ya2   <= ya1;
      xb2   <= xb1;
      yb2   <= yb1;

      pa3   <= tbpf_pkg::PROD_W'(ta2) * tbpf_pkg::PROD_W'(xa2);
      pb3   <= tbpf_pkg::PROD_W'(tb2) * tbpf_pkg::PROD_W'(xb2);
      yd3   <= tbpf_pkg::YD_W'(yb2) - tbpf_pkg::YD_W'(ya2);
      ta3   <= ta2;
      tb3   <= tb2;
      if (vert2) st3 <= tbpf_pkg::ST_VERTICAL;
      else if (ta2 == tb2) st3 <= tbpf_pkg::ST_PARALLEL;
      else st3 <= tbpf_pkg::ST_OK;
      xa3   <= xa2;
      ya3   <= ya2;

      num     <= tbpf_pkg::NUM_W'(pa3) - tbpf_pkg::NUM_W'(pb3) +
                 (tbpf_pkg::NUM_W'(yd3) <<< tbpf_pkg::TAN_FRAC_BITS);
      den     <= tbpf_pkg::DEN_W'(ta3) - tbpf_pkg::DEN_W'(tb3);
      side.ta <= ta3;
      side.xa <= xa3;
      side.ya <= ya3;
      side.st <= st3;
    end
  end

  a_angle_range: assert property (@(posedge clk) disable iff (rst)
    vld1 |-> (aa1 < tbpf_pkg::ANG_W'(tbpf_pkg::ANG_MOD)) &&
             (ab1 < tbpf_pkg::ANG_W'(tbpf_pkg::ANG_MOD)))
    else $error("reduced angle out of range");

endmodule

// File: hw/rtl/tbpf_div.sv
// Pipelined restoring divider, one quotient bit per stage, signed truncation toward zero.
// Depends on tbpf_pkg; carries a side_t alongside each request.
module tbpf_div (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              en,
  input  logic                              in_vld,
  input  logic signed [tbpf_pkg::NUM_W-1:0] in_num,
  input  logic signed [tbpf_pkg::DEN_W-1:0] in_den,
  input  tbpf_pkg::side_t                   in_side,
  output logic                              out_vld,
  output logic signed [tbpf_pkg::NUM_W-1:0] out_quo,
  output tbpf_pkg::side_t                   out_side
);

  localparam int N = tbpf_pkg::NMAG_W;
  localparam int D = tbpf_pkg::DMAG_W;

  logic [N:0]       vld;
  logic [N-1:0]     nq   [N+1];
  logic [D-1:0]     rem  [N+1];
  logic [D-1:0]     dv   [N+1];
  logic             neg  [N+1];
  tbpf_pkg::side_t  sd   [N+1];

  logic [D:0]       trial [N];
  logic [D:0]       diff  [N];
  logic             take  [N];

  logic [tbpf_pkg::NUM_W-1:0] nabs;
  logic [tbpf_pkg::DEN_W-1:0] dabs;

  // Magnitudes of the operands
  always_comb begin
    nabs = in_num[tbpf_pkg::NUM_W-1] ? tbpf_pkg::NUM_W'(-in_num) : tbpf_pkg::NUM_W'(in_num);
    dabs = in_den[tbpf_pkg::DEN_W-1] ? tbpf_pkg::DEN_W'(-in_den) : tbpf_pkg::DEN_W'(in_den);
  end

  // Trial subtract at each stage
  always_comb begin
    for (int i = 0; i < N; i++) begin
      trial[i] = {rem[i], nq[i][N-1]};
      diff[i]  = trial[i] - {1'b0, dv[i]};
      take[i]  = !diff[i][D];
    end
  end

  // Hold valid bits, clear on reset
  always_ff @(posedge clk) begin
    if (rst) begin
      vld     <= '0;
      out_vld <= 1'b0;
    end else if (en) begin
      vld     <= {vld[N-1:0], in_vld};
      out_vld <= vld[N];
    end
  end

  // Advance the payload through the stages
  always_ff @(posedge clk) begin
    if (en) begin
      nq[0]  <= nabs[N-1:0];
      rem[0] <= '0;
      dv[0]  <= dabs[D-1:0];
      neg[0] <= in_num[tbpf_pkg::NUM_W-1] ^ in_den[tbpf_pkg::DEN_W-1];
      sd[0]  <= in_side;
      for (int i = 0; i < N; i++) begin
        rem[i+1] <= take[i] ? diff[i][D-1:0] : trial[i][D-1:0];
        nq[i+1]  <= {nq[i][N-2:0], take[i]};
        dv[i+1]  <= dv[i];
        neg[i+1] <= neg[i];
        sd[i+1]  <= sd[i];
      end
      out_quo  <= neg[N] ? -$signed({1'b0, nq[N]}) : $signed({1'b0, nq[N]});
      out_side <= sd[N];
    end
  end

  a_rem_below_div: assert property (@(posedge clk) disable iff (rst)
    (vld[N] && (dv[N] != '0)) |-> (rem[N] < dv[N]))
    else $error("divider remainder not below divisor");

endmodule

// File: hw/rtl/tbpf_back.sv
// Back stages: clamp x, compute y from the clamped x, clamp y, form status; output register.
// Depends on tbpf_pkg.
module tbpf_back (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               en,
  input  logic                               in_vld,
  input  logic signed [tbpf_pkg::NUM_W-1:0]  quo,
  input  tbpf_pkg::side_t                    side,
  output logic                               out_vld,
  output logic signed [tbpf_pkg::COORD_W-1:0] fix_x,
  output logic signed [tbpf_pkg::COORD_W-1:0] fix_y,
  output tbpf_pkg::status_t                  status
);

  localparam int CW = tbpf_pkg::COORD_W;

  logic                              vld1, vld2, vld3, vld4;
  logic signed [CW-1:0]              x1, x2, x3, x4;
  logic                              sx1, sx2, sx3, sx4;
  tbpf_pkg::side_t                   sd1, sd2, sd3, sd4;
  logic signed [tbpf_pkg::YD_W-1:0]  d2;
  logic signed [tbpf_pkg::YP_W-1:0]  p3;
  logic signed [tbpf_pkg::YQ_W-1:0]  q4;

  logic                              xover;
  logic signed [CW-1:0]              x_next;
  logic signed [tbpf_pkg::YP_W-1:0]  bias;
  logic signed [tbpf_pkg::YS_W-1:0]  ysum;
  logic                              yover;
  logic signed [CW-1:0]              y_next;

  // Clamp the quotient to 32 bits
  always_comb begin
    xover = !((&quo[tbpf_pkg::NUM_W-1:CW-1]) || !(|quo[tbpf_pkg::NUM_W-1:CW-1]));
    if (!xover) x_next = quo[CW-1:0];
    else if (quo[tbpf_pkg::NUM_W-1]) x_next = {1'b1, {(CW-1){1'b0}}};
    else x_next = {1'b0, {(CW-1){1'b1}}};
  end

  // Round toward zero before the shift
  always_comb begin
    bias = p3[tbpf_pkg::YP_W-1] ?
           tbpf_pkg::YP_W'((1 << tbpf_pkg::TAN_FRAC_BITS) - 1) : '0;
  end

  // Add y of point A and clamp
  always_comb begin
    ysum  = tbpf_pkg::YS_W'(q4) + tbpf_pkg::YS_W'(sd4.ya);
    yover = !((&ysum[tbpf_pkg::YS_W-1:CW-1]) || !(|ysum[tbpf_pkg::YS_W-1:CW-1]));
    if (!yover) y_next = ysum[CW-1:0];
    else if (ysum[tbpf_pkg::YS_W-1]) y_next = {1'b1, {(CW-1){1'b0}}};
    else y_next = {1'b0, {(CW-1){1'b1}}};
  end

  // Hold valid bits, clear on reset
  always_ff @(posedge clk) begin
    if (rst) begin
      vld1    <= 1'b0;
      vld2    <= 1'b0;
      vld3    <= 1'b0;
      vld4    <= 1'b0;
      out_vld <= 1'b0;
    end else if (en) begin
      vld1    <= in_vld;
      vld2    <= vld1;
      vld3    <= vld2;
      vld4    <= vld3;
      out_vld <= vld4;
    end
  end

  // Advance the payload
  always_ff @(posedge clk) begin
    if (en) begin
      x1  <= x_next;
      sx1 <= xover;
      sd1 <= side;

      d2  <= tbpf_pkg::YD_W'(x1) - tbpf_pkg::YD_W'(sd1.xa);
      x2  <= x1;
      sx2 <= sx1;
      sd2 <= sd1;

      p3  <= tbpf_pkg::YP_W'($signed(sd2.ta)) * tbpf_pkg::YP_W'(d2);
      x3  <= x2;
      sx3 <= sx2;
      sd3 <= sd2;

      q4  <= tbpf_pkg::YQ_W'((p3 + bias) >>> tbpf_pkg::TAN_FRAC_BITS);
      x4  <= x3;
      sx4 <= sx3;
      sd4 <= sd3;

      if (sd4.st != tbpf_pkg::ST_OK) begin
        fix_x  <= '0;
        fix_y  <= '0;
        status <= sd4.st;
      end else begin
        fix_x  <= x4;
        fix_y  <= y_next;
        status <= (sx4 || yover) ? tbpf_pkg::ST_SAT : tbpf_pkg::ST_OK;
      end
    end
  end

  a_sat_flag: assert property (@(posedge clk) disable iff (rst)
    (en && vld4 && sd4.st == tbpf_pkg::ST_OK && sx4) |=> (status == tbpf_pkg::ST_SAT))
    else $error("clamped x without saturation status");

endmodule

// File: hw/rtl/two_bearing_position_fix_top.sv
// Two-bearing position fix: pipeline of front stages, divider and back stages.
// One request enters per cycle while in_stall is low; the 57-stage divider forms one quotient
// bit per stage. A single stall stops the whole pipe only while a finished fix waits at the
// output. The user must write north_offset through cfg_* when the block is idle; the block
// does not enforce this. Depends on tbpf_pkg, tbpf_front, tbpf_div and tbpf_back.
module two_bearing_position_fix_top (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [tbpf_pkg::BEAR_W-1:0]         cfg_data,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [tbpf_pkg::BEAR_W-1:0]         bearing_a,
  input  logic [tbpf_pkg::BEAR_W-1:0]         bearing_b,
  input  logic signed [tbpf_pkg::COORD_W-1:0] ref_a_x,
  input  logic signed [tbpf_pkg::COORD_W-1:0] ref_a_y,
  input  logic signed [tbpf_pkg::COORD_W-1:0] ref_b_x,
  input  logic signed [tbpf_pkg::COORD_W-1:0] ref_b_y,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [tbpf_pkg::COORD_W-1:0] fix_x,
  output logic signed [tbpf_pkg::COORD_W-1:0] fix_y,
  output logic [tbpf_pkg::ST_W-1:0]           status
);

  logic [tbpf_pkg::BEAR_W-1:0]        north_offset;
  logic                               en;
  logic                               f_vld, d_vld;
  logic signed [tbpf_pkg::NUM_W-1:0]  f_num, d_quo;
  logic signed [tbpf_pkg::DEN_W-1:0]  f_den;
  tbpf_pkg::side_t                    f_side, d_side;
  tbpf_pkg::status_t                  st;

  assign cfg_ready = 1'b1;
  assign en        = !(out_valid && out_stall);
  assign in_stall  = !en;
  assign status    = st;

  // Hold the north offset register
  always_ff @(posedge clk) begin
    if (rst) begin
      north_offset <= '0;
    end else if (cfg_valid && cfg_ready) begin
      north_offset <= cfg_data;
    end
  end

  tbpf_front u_front (
    .clk          (clk),
    .rst          (rst),
    .en           (en),
    .north_offset (north_offset),
    .in_vld       (in_valid),
    .bearing_a    (bearing_a),
    .bearing_b    (bearing_b),
    .ref_a_x      (ref_a_x),
    .ref_a_y      (ref_a_y),
    .ref_b_x      (ref_b_x),
    .ref_b_y      (ref_b_y),
    .out_vld      (f_vld),
    .num          (f_num),
    .den          (f_den),
    .side         (f_side)
  );

  tbpf_div u_div (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_vld   (f_vld),
    .in_num   (f_num),
    .in_den   (f_den),
    .in_side  (f_side),
    .out_vld  (d_vld),
    .out_quo  (d_quo),
    .out_side (d_side)
  );

  tbpf_back u_back (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .in_vld  (d_vld),
    .quo     (d_quo),
    .side    (d_side),
    .out_vld (out_valid),
    .fix_x   (fix_x),
    .fix_y   (fix_y),
    .status  (st)
  );

  a_special_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (st == tbpf_pkg::ST_PARALLEL || st == tbpf_pkg::ST_VERTICAL)) |->
      (fix_x == '0 && fix_y == '0))
    else $error("special status with nonzero fix");

  a_stall_only_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid)
    else $error("input stalled with no result waiting");

endmodule

// File: verif/testbench.sv
// Self-checking testbench for two_bearing_position_fix_top: directed and random fixes,
// offset changes between phases, random idling on both sides and a long output hold-off.
// Depends on tbpf_pkg and two_bearing_position_fix_top.
module testbench;

  typedef struct {
    logic signed [tbpf_pkg::COORD_W-1:0] x;
    logic signed [tbpf_pkg::COORD_W-1:0] y;
    tbpf_pkg::status_t                   st;
  } fix_t;

  logic clk;
  logic rst;
  logic cfg_valid;
  logic cfg_ready;
  logic [tbpf_pkg::BEAR_W-1:0] cfg_data;
  logic in_valid;
  logic in_stall;
  logic [tbpf_pkg::BEAR_W-1:0] bearing_a;
  logic [tbpf_pkg::BEAR_W-1:0] bearing_b;
  logic signed [tbpf_pkg::COORD_W-1:0] ref_a_x;
  logic signed [tbpf_pkg::COORD_W-1:0] ref_a_y;
  logic signed [tbpf_pkg::COORD_W-1:0] ref_b_x;
  logic signed [tbpf_pkg::COORD_W-1:0] ref_b_y;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [tbpf_pkg::COORD_W-1:0] fix_x;
  logic signed [tbpf_pkg::COORD_W-1:0] fix_y;
  logic [tbpf_pkg::ST_W-1:0] status;

  fix_t   pending_fixes[$];
  longint tan_q16[tbpf_pkg::ANG_HALF];
  int     offset_deg;
  int     error_count = 0;
  bit     quiet;
  bit     hold_go;
  bit     hold_seen;
  int     hold_left;
  int     stall_left;

  two_bearing_position_fix_top uut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .bearing_a(bearing_a), .bearing_b(bearing_b),
    .ref_a_x(ref_a_x), .ref_a_y(ref_a_y), .ref_b_x(ref_b_x), .ref_b_y(ref_b_y),
    .out_valid(out_valid), .out_stall(out_stall),
    .fix_x(fix_x), .fix_y(fix_y), .status(status)
  );

  always begin
    clk = 1'b0; #5;
    clk = 1'b1; #5;
  end

  initial begin
    #10000000;
    $display("CHECK FAILED");
    $finish;
  end

  // Tangent of 0..89 degrees: Taylor sin/cos in Q2.30, quotient in Q.24, rounded to Q.16
  function automatic longint first_quadrant_tan(int k);
    longint unsigned ang;
    longint unsigned ang_sq;
    longint unsigned sin_term;
    longint unsigned cos_term;
    longint unsigned q24;
    longint sin_sum;
    longint cos_sum;
    longint unsigned m;
    int sh;
    sh = 24 - tbpf_pkg::TAN_FRAC_BITS;
    ang = (longint'(k) * 64'd3373259422 + 64'd90) / 64'd180;
    ang_sq = (ang * ang) >> 30;
    sin_term = ang;
    cos_term = 64'd1073741824;
    sin_sum = longint'(ang);
    cos_sum = 64'sd1073741824;
    for (int i = 1; i <= 12; i++) begin
      m = longint'(i);
      sin_term = ((sin_term * ang_sq) >> 30) / ((2 * m) * (2 * m + 1));
      cos_term = ((cos_term * ang_sq) >> 30) / ((2 * m - 1) * (2 * m));
      if (i % 2 == 1) begin
        sin_sum -= longint'(sin_term);
        cos_sum -= longint'(cos_term);
      end else begin
        sin_sum += longint'(sin_term);
        cos_sum += longint'(cos_term);
      end
    end
    if (sin_sum < 0) sin_sum = 0;
    if (cos_sum <= 0) cos_sum = 1;
    q24 = (($unsigned(sin_sum) << 24) + $unsigned(cos_sum) / 2) / $unsigned(cos_sum);
    if (sh > 0) q24 = (q24 + (64'd1 << (sh - 1))) >> sh;
    return longint'(q24);
  endfunction

  function automatic longint line_slope(int ang);
    if (ang < tbpf_pkg::ANG_HALF) return tan_q16[ang];
    return -tan_q16[tbpf_pkg::ANG_MOD - ang];
  endfunction

  function automatic longint clamp_s32(longint v, ref bit sat);
    if (v > 64'sd2147483647) begin
      sat = 1'b1;
      return 64'sd2147483647;
    end
    if (v < -64'sd2147483648) begin
      sat = 1'b1;
      return -64'sd2147483648;
    end
    return v;
  endfunction

  // Intersect the two bearing lines under the current north offset
  function automatic fix_t predict_fix(int ba, int bb, longint xa, longint ya,
                                       longint xb, longint yb);
    fix_t   f;
    int     aa;
    int     ab;
    longint ta;
    longint tb;
    longint num;
    longint xv;
    longint yv;
    bit     sat;
    aa = (ba + offset_deg) % tbpf_pkg::ANG_MOD;
    ab = (bb + offset_deg) % tbpf_pkg::ANG_MOD;
    f.x = '0;
    f.y = '0;
    sat = 1'b0;
    if (aa == tbpf_pkg::ANG_HALF || ab == tbpf_pkg::ANG_HALF) begin
      f.st = tbpf_pkg::ST_VERTICAL;
      return f;
    end
    ta = line_slope(aa);
    tb = line_slope(ab);
    if (ta == tb) begin
      f.st = tbpf_pkg::ST_PARALLEL;
      return f;
    end
    num = ta * xa - tb * xb + (yb - ya) * (64'sd1 << tbpf_pkg::TAN_FRAC_BITS);
    xv = clamp_s32(num / (ta - tb), sat);
    yv = clamp_s32((ta * (xv - xa)) / (64'sd1 << tbpf_pkg::TAN_FRAC_BITS) + ya, sat);
    f.x = xv[tbpf_pkg::COORD_W-1:0];
    f.y = yv[tbpf_pkg::COORD_W-1:0];
    f.st = sat ? tbpf_pkg::ST_SAT : tbpf_pkg::ST_OK;
    return f;
  endfunction

  function automatic int gap_len();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Offer one request, hold it until accepted, then queue its expected fix
  task automatic send_fix(int ba, int bb, logic [31:0] xa, logic [31:0] ya,
                          logic [31:0] xb, logic [31:0] yb);
    int   g;
    fix_t f;
    in_valid <= 1'b1;
    bearing_a <= ba[tbpf_pkg::BEAR_W-1:0];
    bearing_b <= bb[tbpf_pkg::BEAR_W-1:0];
    ref_a_x <= xa;
    ref_a_y <= ya;
    ref_b_x <= xb;
    ref_b_y <= yb;
    forever begin
      @(negedge clk);
      if (!in_stall) break;
      @(posedge clk);
    end
    @(posedge clk);
    f = predict_fix(ba, bb, longint'($signed(xa)), longint'($signed(ya)),
                    longint'($signed(xb)), longint'($signed(yb)));
    pending_fixes.insert(pending_fixes.size(), f);
    g = gap_len();
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_fixes.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  // Write the north offset once the pipe is empty
  task automatic set_offset(int deg);
    drain();
    cfg_valid <= 1'b1;
    cfg_data <= deg[tbpf_pkg::BEAR_W-1:0];
    forever begin
      @(negedge clk);
      if (cfg_ready) break;
      @(posedge clk);
    end
    @(posedge clk);
    cfg_valid <= 1'b0;
    offset_deg = deg;
  endtask

  function automatic logic [31:0] rand_coord();
    int r;
    r = $urandom_range(0, 9);
    if (r < 2) return $urandom();
    if (r < 8) return $signed($urandom_range(0, 32'h0FFF_FFFF)) - 32'sh0800_0000;
    return $signed($urandom_range(0, 32'h00FF_FFFF)) - 32'sh0080_0000;
  endfunction

  task automatic test_directed();
    send_fix(0, 45, 0, 0, 32'h0100_0000, 0);
    send_fix(90, 10, 32'h0100_0000, 0, 0, 0);
    send_fix(30, 270, 0, 0, 0, 0);
    send_fix(30, 30, 32'h0100_0000, 0, 0, 32'h0100_0000);
    send_fix(20, 200, 0, 0, 32'h0200_0000, 0);
    send_fix(511, 0, 32'h0100_0000, 32'h0100_0000, 0, 0);
    send_fix(359, 179, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF);
    send_fix(89, 91, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000);
    send_fix(1, 0, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000);
    send_fix(89, 88, 0, 0, 32'h7FFF_FFFF, 0);
    send_fix(0, 179, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 0);
    send_fix(135, 45, 32'h0100_0000, 0, 32'hFF00_0000, 0);
    send_fix(450, 1, 0, 0, 0, 0);
    send_fix(60, 120, 32'h0000_0001, 32'hFFFF_FFFF, 32'h8000_0001, 32'h7FFF_FFFE);
  endtask

  task automatic test_random(int n);
    int ba;
    int bb;
    for (int i = 0; i < n; i++) begin
      ba = $urandom_range(0, 511);
      bb = ($urandom_range(0, 9) == 0) ? ba + 180 * $urandom_range(0, 1)
                                       : $urandom_range(0, 511);
      if (bb > 511) bb -= 180;
      send_fix(ba, bb, rand_coord(), rand_coord(), rand_coord(), rand_coord());
    end
  endtask

  // Hold the output off for a long stretch while requests keep coming
  task automatic test_backpressure();
    quiet = 1'b1;
    hold_go = ~hold_go;
    test_random(150);
    quiet = 1'b0;
  endtask

  // Output side: random stalls, bursts of long stalls, and a requested hold-off
  always @(posedge clk) begin
    if (hold_go != hold_seen) begin
      hold_seen <= hold_go;
      hold_left <= 300;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall <= 1'b1;
    end else if (quiet) begin
      out_stall <= 1'b0;
    end else if ($urandom_range(0, 99) < 3) begin
      stall_left <= $urandom_range(10, 40);
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < 25);
    end
  end

  // Compare each fix taken at the coming edge with the oldest expectation
  always @(negedge clk) begin
    fix_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_fixes.size() == 0) begin
        $display("%0t: unexpected fix x=%h y=%h status=%0d", $time, fix_x, fix_y, status);
        error_count++;
      end else begin
        want = pending_fixes.pop_front();
        if (fix_x !== want.x) begin
          $display("%0t: fix_x expected %h actual %h", $time, want.x, fix_x);
          error_count++;
        end
        if (fix_y !== want.y) begin
          $display("%0t: fix_y expected %h actual %h", $time, want.y, fix_y);
          error_count++;
        end
        if (status !== want.st) begin
          $display("%0t: status expected %0d actual %0d", $time, want.st, status);
          error_count++;
        end
      end
    end
  end

  initial begin
    for (int k = 0; k < tbpf_pkg::ANG_HALF; k++) tan_q16[k] = first_quadrant_tan(k);
    offset_deg = 0;
    quiet = 1'b0;
    hold_go = 1'b0;
    rst = 1'b1;
    cfg_valid = 1'b0;
    cfg_data = '0;
    in_valid = 1'b0;
    bearing_a = '0;
    bearing_b = '0;
    ref_a_x = '0;
    ref_a_y = '0;
    ref_b_x = '0;
    ref_b_y = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_random(300);
    set_offset(359);
    test_directed();
    test_random(250);
    set_offset(1);
    quiet = 1'b1;
    test_random(200);
    quiet = 1'b0;
    test_backpressure();
    set_offset(180);
    test_random(200);
    set_offset(90);
    test_random(150);
    set_offset($urandom_range(0, 359));
    test_random(150);
    set_offset(0);
    test_random(50);
    drain();

    if (error_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
